[design/abc_pkg.sv]
// ----------------------------------------------------------------------------
// Alternating-bit channel package
// Shared widths, event and status codes, register indexes, reset values and
// the structs that travel between the channel's modules.
// ----------------------------------------------------------------------------
package abc_pkg;

    localparam int SEQ_W      = 8;
    localparam int SIZE_W     = 16;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LIMIT_W    = 16;

    // Event codes carried in func.
    localparam logic [FUNC_W-1:0] FUNC_POST    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FRAME   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PROCESS = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FINISH  = 2'd3;

    // Post status codes.
    localparam logic [STATUS_W-1:0] PS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] PS_BUSY     = 2'd1;
    localparam logic [STATUS_W-1:0] PS_SIZE_BAD = 2'd2;
    localparam logic [STATUS_W-1:0] PS_NOT_POST = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_SECOND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [SEQ_W-1:0]   SEQ_FIRST_RST   = 8'd1;
    localparam logic [SEQ_W-1:0]   SEQ_SECOND_RST  = 8'd2;
    localparam logic [LIMIT_W-1:0] TIMEOUT_RST     = 16'd10;
    localparam logic [SIZE_W-1:0]  MAX_PAYLOAD_RST = 16'd256;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SIZE_W-1:0] payload_size;
        logic [SEQ_W-1:0]  rx_seq_in;
        logic [SEQ_W-1:0]  tx_ack_seq;
        logic              handler_accepts;
        logic [SIZE_W-1:0] rx_payload_size;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] post_status;
        logic [SEQ_W-1:0]    tx_seq_out;
        logic                deliver_valid;
        logic [SIZE_W-1:0]   deliver_size;
        logic                rx_flag_write;
        logic [SEQ_W-1:0]    rx_flag_value;
        logic                process_ok;
        logic                tx_locked;
        logic                tx_acknowledged;
        logic                tx_timed_out;
    } rsp_t;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq_value_first;
        logic [SEQ_W-1:0]   seq_value_second;
        logic [LIMIT_W-1:0] timeout_limit;
        logic [SIZE_W-1:0]  max_payload;
    } cfg_t;

endpackage

[design/abc_cmd_if.sv]
// ----------------------------------------------------------------------------
// Alternating-bit channel event interface
// Valid/ready channel carrying one event request and its fields.
// ----------------------------------------------------------------------------
interface abc_cmd_if;

    logic                         valid;
    logic                         ready;
    logic [abc_pkg::FUNC_W-1:0]   func;
    logic [abc_pkg::SIZE_W-1:0]   payload_size;
    logic [abc_pkg::SEQ_W-1:0]    rx_seq_in;
    logic [abc_pkg::SEQ_W-1:0]    tx_ack_seq;
    logic                         handler_accepts;
    logic [abc_pkg::SIZE_W-1:0]   rx_payload_size;

    modport source (
        output valid, func, payload_size, rx_seq_in, tx_ack_seq,
               handler_accepts, rx_payload_size,
        input  ready
    );

    modport sink (
        input  valid, func, payload_size, rx_seq_in, tx_ack_seq,
               handler_accepts, rx_payload_size,
        output ready
    );

endinterface

[design/abc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Alternating-bit channel result interface
// Valid/ready channel carrying one result request per event.
// ----------------------------------------------------------------------------
interface abc_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [abc_pkg::STATUS_W-1:0]   post_status;
    logic [abc_pkg::SEQ_W-1:0]      tx_seq_out;
    logic                           deliver_valid;
    logic [abc_pkg::SIZE_W-1:0]     deliver_size;
    logic                           rx_flag_write;
    logic [abc_pkg::SEQ_W-1:0]      rx_flag_value;
    logic                           process_ok;
    logic                           tx_locked;
    logic                           tx_acknowledged;
    logic                           tx_timed_out;

    modport source (
        output valid, post_status, tx_seq_out, deliver_valid, deliver_size,
               rx_flag_write, rx_flag_value, process_ok, tx_locked,
               tx_acknowledged, tx_timed_out,
        input  ready
    );

    modport sink (
        input  valid, post_status, tx_seq_out, deliver_valid, deliver_size,
               rx_flag_write, rx_flag_value, process_ok, tx_locked,
               tx_acknowledged, tx_timed_out,
        output ready
    );

endinterface

[design/abc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Alternating-bit channel configuration registers
// Holds the sequence encodings, the timeout limit and the size limit.
// ----------------------------------------------------------------------------
module abc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               we,
    input  logic [abc_pkg::CFG_IDX_W-1:0]      index,
    input  logic [abc_pkg::CFG_DATA_W-1:0]     data,
    output abc_pkg::cfg_t                      cfg
);

    abc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seq_value_first  <= abc_pkg::SEQ_FIRST_RST;
            cfg_reg.seq_value_second <= abc_pkg::SEQ_SECOND_RST;
            cfg_reg.timeout_limit    <= abc_pkg::TIMEOUT_RST;
            cfg_reg.max_payload      <= abc_pkg::MAX_PAYLOAD_RST;
        end
        else if (we)
        begin
            unique case (index)
                abc_pkg::REG_SEQ_FIRST:
                    cfg_reg.seq_value_first <= data[abc_pkg::SEQ_W-1:0];
                abc_pkg::REG_SEQ_SECOND:
                    cfg_reg.seq_value_second <= data[abc_pkg::SEQ_W-1:0];
                abc_pkg::REG_TIMEOUT:
                    cfg_reg.timeout_limit <= data[abc_pkg::LIMIT_W-1:0];
                abc_pkg::REG_MAX_PAYLOAD:
                    cfg_reg.max_payload <= data[abc_pkg::SIZE_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/abc_core.sv]
// ----------------------------------------------------------------------------
// Alternating-bit channel protocol core
// Holds the channel state and evaluates one event per step.
// ----------------------------------------------------------------------------
module abc_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  abc_pkg::cmd_t  cmd,
    input  abc_pkg::cfg_t  cfg,
    output abc_pkg::rsp_t  rsp
);

    localparam int CMP_W = (TIMER_BITS > abc_pkg::LIMIT_W) ? TIMER_BITS : abc_pkg::LIMIT_W;

    logic [abc_pkg::SEQ_W-1:0] tx_sequence_reg, tx_sequence_next;
    logic [abc_pkg::SEQ_W-1:0] rx_sequence_reg, rx_sequence_next;
    logic                      rx_pending_reg, rx_pending_next;
    logic                      tx_busy_reg, tx_busy_next;
    logic                      timer_running_reg, timer_running_next;
    logic [TIMER_BITS-1:0]     timer_count_reg, timer_count_next;

    logic [abc_pkg::SEQ_W-1:0] tx_toggled;
    logic                      timer_expired;
    logic                      size_bad;
    logic                      rx_seq_known;
    logic                      pass;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_sequence_reg   <= abc_pkg::SEQ_SECOND_RST;
            rx_sequence_reg   <= '0;
            rx_pending_reg    <= 1'b0;
            tx_busy_reg       <= 1'b0;
            timer_running_reg <= 1'b0;
            timer_count_reg   <= '0;
        end
        else if (step)
        begin
            tx_sequence_reg   <= tx_sequence_next;
            rx_sequence_reg   <= rx_sequence_next;
            rx_pending_reg    <= rx_pending_next;
            tx_busy_reg       <= tx_busy_next;
            timer_running_reg <= timer_running_next;
            timer_count_reg   <= timer_count_next;
        end
    end

    assign tx_toggled = (tx_sequence_reg == cfg.seq_value_first) ?
                        cfg.seq_value_second : cfg.seq_value_first;
    assign timer_expired = timer_running_reg &&
                           (CMP_W'(timer_count_reg) >= CMP_W'(cfg.timeout_limit));
    assign size_bad = (cmd.payload_size == '0) || (cmd.payload_size > cfg.max_payload);
    assign rx_seq_known = (cmd.rx_seq_in == cfg.seq_value_first) ||
                          (cmd.rx_seq_in == cfg.seq_value_second);

    always_comb
    begin
        tx_sequence_next   = tx_sequence_reg;
        rx_sequence_next   = rx_sequence_reg;
        rx_pending_next    = rx_pending_reg;
        tx_busy_next       = tx_busy_reg;
        timer_running_next = timer_running_reg;
        timer_count_next   = timer_count_reg;
        pass               = 1'b1;

        rsp                 = '0;
        rsp.post_status     = abc_pkg::PS_NOT_POST;
        rsp.process_ok      = 1'b1;

        unique case (cmd.func)
            abc_pkg::FUNC_POST:
            begin
                if (size_bad)
                begin
                    rsp.post_status = abc_pkg::PS_SIZE_BAD;
                end
                else if (tx_busy_reg)
                begin
                    rsp.post_status = abc_pkg::PS_BUSY;
                end
                else
                begin
                    rsp.post_status    = abc_pkg::PS_OK;
                    rsp.tx_seq_out     = tx_sequence_reg;
                    tx_busy_next       = 1'b1;
                    timer_running_next = 1'b1;
                    timer_count_next   = '0;
                end
            end
            abc_pkg::FUNC_FRAME:
            begin
                // The timer saturates at all ones.
                if (timer_running_reg && (timer_count_reg != {TIMER_BITS{1'b1}}))
                begin
                    timer_count_next = timer_count_reg + TIMER_BITS'(1);
                end
                if (rx_seq_known && (cmd.rx_seq_in != rx_sequence_reg))
                begin
                    rx_pending_next  = 1'b1;
                    rx_sequence_next = cmd.rx_seq_in;
                end
            end
            abc_pkg::FUNC_PROCESS:
            begin
                if (rx_pending_reg)
                begin
                    rsp.deliver_valid = 1'b1;
                    rsp.deliver_size  = cmd.rx_payload_size;
                    if (!cmd.handler_accepts)
                    begin
                        pass              = 1'b0;
                        rsp.process_ok    = 1'b0;
                        rsp.rx_flag_write = 1'b1;
                        rsp.rx_flag_value = rx_sequence_reg;
                        rx_pending_next   = 1'b0;
                    end
                end
                // An acknowledge wins over a timeout in the same step.
                if (pass && tx_busy_reg)
                begin
                    if (cmd.tx_ack_seq == tx_sequence_reg)
                    begin
                        tx_busy_next        = 1'b0;
                        tx_sequence_next    = tx_toggled;
                        timer_running_next  = 1'b0;
                        rsp.tx_acknowledged = 1'b1;
                    end
                    else if (timer_expired)
                    begin
                        tx_busy_next       = 1'b0;
                        tx_sequence_next   = tx_toggled;
                        timer_running_next = 1'b0;
                        rsp.tx_timed_out   = 1'b1;
                    end
                end
            end
            abc_pkg::FUNC_FINISH:
            begin
                rsp.rx_flag_write = 1'b1;
                rsp.rx_flag_value = rx_sequence_reg;
                rx_pending_next   = 1'b0;
            end
            default:
            begin
                rsp.post_status = abc_pkg::PS_NOT_POST;
            end
        endcase

        rsp.tx_locked = tx_busy_next;
    end

endmodule

[design/alternating_bit_channel.sv]
// ----------------------------------------------------------------------------
// Alternating-bit channel
// One channel of an alternating-bit exchange: posts, frame-seen ticks,
// process steps and receive-finished events, one result per event.
//
//   Channel   Role     Handshake      Payload
//   cmd       sink     valid/ready    func and the event fields
//   rsp       source   valid/ready    status, sequence and unlock flags
//   cfg_*     sink     write enable   register index and write data
//
// Flow: one event request is accepted every cycle while the input register
// is free or advancing. A request lands in the input register when it is
// accepted, is evaluated there against the channel state and moves into
// the result register, where it is valid, once that register is free.
// Reset: rst_n clears the channel state and loads the register defaults.
// Stalls: while the result register is held by rsp.ready low, the input
// register still takes one more request; the state advances only when a
// result moves into the result register.
// ----------------------------------------------------------------------------
module alternating_bit_channel #(
    parameter int TIMER_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    abc_cmd_if.sink                           cmd,
    abc_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [abc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [abc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Input register: holds one accepted request until it can be evaluated.
    logic          in_valid_reg;
    abc_pkg::cmd_t cmd_reg;

    // Result register: holds one finished result until the sink takes it.
    logic          out_valid_reg;
    abc_pkg::rsp_t rsp_reg;

    abc_pkg::cfg_t cfg;
    abc_pkg::rsp_t rsp_comb;
    logic          advance;
    logic          cmd_take;

    // A request moves from the input register into the result register
    // whenever the result register is empty or being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign cmd_take = cmd.valid && cmd.ready;

    abc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    abc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cmd   (cmd_reg),
        .cfg   (cfg),
        .rsp   (rsp_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg.func            <= cmd.func;
            cmd_reg.payload_size    <= cmd.payload_size;
            cmd_reg.rx_seq_in       <= cmd.rx_seq_in;
            cmd_reg.tx_ack_seq      <= cmd.tx_ack_seq;
            cmd_reg.handler_accepts <= cmd.handler_accepts;
            cmd_reg.rx_payload_size <= cmd.rx_payload_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_comb;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.post_status     = rsp_reg.post_status;
    assign rsp.tx_seq_out      = rsp_reg.tx_seq_out;
    assign rsp.deliver_valid   = rsp_reg.deliver_valid;
    assign rsp.deliver_size    = rsp_reg.deliver_size;
    assign rsp.rx_flag_write   = rsp_reg.rx_flag_write;
    assign rsp.rx_flag_value   = rsp_reg.rx_flag_value;
    assign rsp.process_ok      = rsp_reg.process_ok;
    assign rsp.tx_locked       = rsp_reg.tx_locked;
    assign rsp.tx_acknowledged = rsp_reg.tx_acknowledged;
    assign rsp.tx_timed_out    = rsp_reg.tx_timed_out;

    // An accepted request always occupies the input register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> in_valid_reg)
    else $error("accepted request lost from the input register");

    // Acknowledge and timeout never unlock in the same step.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(rsp_reg.tx_acknowledged && rsp_reg.tx_timed_out))
    else $error("acknowledge and timeout reported together");

    // A step that unlocks the transmit side must report it unlocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (rsp_reg.tx_acknowledged || rsp_reg.tx_timed_out)
        |-> !rsp_reg.tx_locked)
    else $error("unlock step reports transmit still locked");

    // A refused frame was forwarded and frees the receive side.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp_reg.process_ok
        |-> rsp_reg.deliver_valid && rsp_reg.rx_flag_write)
    else $error("refused process step without delivery and flag write");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternating-bit channel testbench
// Drives event requests into the channel and follows each one with a
// cycle-free model of the channel state. Every result request is compared
// field by field with the oldest predicted result. The run covers directed
// corner cases, timeouts, back-pressure and random exchanges under
// several register settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int TIMER_BITS   = 16;
    // After the channel has answered every request, this margin is waited
    // out before the registers are touched or the run ends.
    localparam int DRAIN_CYCLES = 6;

    logic clk = 1'b0;
    logic rst_n;
    logic                           cfg_we;
    logic [abc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [abc_pkg::CFG_DATA_W-1:0] cfg_data;

    abc_cmd_if cmd_bus ();
    abc_rsp_if rsp_bus ();

    alternating_bit_channel #(
        .TIMER_BITS (TIMER_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Channel model. These variables mirror the channel state and the
    // register copy, and are advanced once per accepted event request.
    // ------------------------------------------------------------------------
    abc_pkg::cfg_t              ch_cfg;
    logic [abc_pkg::SEQ_W-1:0]  ch_tx_seq;
    logic [abc_pkg::SEQ_W-1:0]  ch_rx_seq;
    logic                       ch_rx_pending;
    logic                       ch_tx_busy;
    logic                       ch_timer_on;
    logic [TIMER_BITS-1:0]      ch_timer_cnt;

    // Results that the channel still owes, oldest first.
    abc_pkg::rsp_t pending_results[$];

    int  fail_count  = 0;
    int  rsp_count   = 0;
    int  items_sent  = 0;

    // Sender bursts and receiver stalls can be switched off for stretches
    // where speed matters more than timing variety.
    bit  cmd_gaps_on  = 1'b1;
    bit  rsp_stall_on = 1'b1;
    int  burst_left   = 8;
    // A nonzero value asks the receiver to hold off; it sets the hold length.
    int  rsp_hold_len = 0;

    // The alternation rule: the first encoding goes to the second, anything
    // else goes to the first. With equal encodings the value settles on that encoding and then never moves.
    function automatic logic [abc_pkg::SEQ_W-1:0] toggled_seq(
        input logic [abc_pkg::SEQ_W-1:0] s);
        return (s == ch_cfg.seq_value_first) ? ch_cfg.seq_value_second
                                             : ch_cfg.seq_value_first;
    endfunction

    // Applies one event to the model state and returns the result that the
    // channel has to produce for it.
    function automatic abc_pkg::rsp_t predict_event(input abc_pkg::cmd_t c);
        abc_pkg::rsp_t r;
        logic go_on;
        r             = '0;
        r.post_status = abc_pkg::PS_NOT_POST;
        r.process_ok  = 1'b1;
        go_on         = 1'b1;
        case (c.func)
            abc_pkg::FUNC_POST:
            begin
                // The size check wins over the busy check.
                if (c.payload_size == '0 || c.payload_size > ch_cfg.max_payload)
                    r.post_status = abc_pkg::PS_SIZE_BAD;
                else if (ch_tx_busy)
                    r.post_status = abc_pkg::PS_BUSY;
                else
                begin
                    r.post_status = abc_pkg::PS_OK;
                    r.tx_seq_out  = ch_tx_seq;
                    ch_tx_busy    = 1'b1;
                    ch_timer_on   = 1'b1;
                    ch_timer_cnt  = '0;
                end
            end
            abc_pkg::FUNC_FRAME:
            begin
                // The timer saturates instead of wrapping.
                if (ch_timer_on && ch_timer_cnt != {TIMER_BITS{1'b1}})
                    ch_timer_cnt = ch_timer_cnt + TIMER_BITS'(1);
                // Only a valid encoding that differs from the last one counts
                // as a new incoming frame.
                if ((c.rx_seq_in == ch_cfg.seq_value_first ||
                     c.rx_seq_in == ch_cfg.seq_value_second) &&
                    c.rx_seq_in != ch_rx_seq)
                begin
                    ch_rx_pending = 1'b1;
                    ch_rx_seq     = c.rx_seq_in;
                end
            end
            abc_pkg::FUNC_PROCESS:
            begin
                if (ch_rx_pending)
                begin
                    r.deliver_valid = 1'b1;
                    r.deliver_size  = c.rx_payload_size;
                    if (!c.handler_accepts)
                    begin
                        // A refused frame frees the receive side and skips
                        // the transmit handling of this step.
                        go_on           = 1'b0;
                        r.process_ok    = 1'b0;
                        r.rx_flag_write = 1'b1;
                        r.rx_flag_value = ch_rx_seq;
                        ch_rx_pending   = 1'b0;
                    end
                end
                if (go_on && ch_tx_busy)
                begin
                    // Acknowledge has priority over timeout.
                    if (c.tx_ack_seq == ch_tx_seq)
                    begin
                        ch_tx_busy        = 1'b0;
                        ch_tx_seq         = toggled_seq(ch_tx_seq);
                        ch_timer_on       = 1'b0;
                        r.tx_acknowledged = 1'b1;
                    end
                    else if (ch_timer_on && ch_timer_cnt >= ch_cfg.timeout_limit)
                    begin
                        ch_tx_busy     = 1'b0;
                        ch_tx_seq      = toggled_seq(ch_tx_seq);
                        ch_timer_on    = 1'b0;
                        r.tx_timed_out = 1'b1;
                    end
                end
            end
            abc_pkg::FUNC_FINISH:
            begin
                // The flag is written even when no frame is pending.
                r.rx_flag_write = 1'b1;
                r.rx_flag_value = ch_rx_seq;
                ch_rx_pending   = 1'b0;
            end
        endcase
        r.tx_locked = ch_tx_busy;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Event builders. Fields that an event does not use are left random so
    // that the channel is seen to ignore them.
    // ------------------------------------------------------------------------
    function automatic abc_pkg::cmd_t noise_cmd();
        abc_pkg::cmd_t c;
        c.func            = abc_pkg::FUNC_W'($urandom_range(0, 3));
        c.payload_size    = abc_pkg::SIZE_W'($urandom);
        c.rx_seq_in       = abc_pkg::SEQ_W'($urandom);
        c.tx_ack_seq      = abc_pkg::SEQ_W'($urandom);
        c.handler_accepts = 1'($urandom);
        c.rx_payload_size = abc_pkg::SIZE_W'($urandom);
        return c;
    endfunction

    function automatic abc_pkg::cmd_t post_cmd(input logic [abc_pkg::SIZE_W-1:0] size);
        abc_pkg::cmd_t c;
        c              = noise_cmd();
        c.func         = abc_pkg::FUNC_POST;
        c.payload_size = size;
        return c;
    endfunction

    function automatic abc_pkg::cmd_t frame_cmd(input logic [abc_pkg::SEQ_W-1:0] rx_seq);
        abc_pkg::cmd_t c;
        c           = noise_cmd();
        c.func      = abc_pkg::FUNC_FRAME;
        c.rx_seq_in = rx_seq;
        return c;
    endfunction

    function automatic abc_pkg::cmd_t process_cmd(input logic [abc_pkg::SEQ_W-1:0] ack,
                                                  input logic accepts,
                                                  input logic [abc_pkg::SIZE_W-1:0] rx_size);
        abc_pkg::cmd_t c;
        c                 = noise_cmd();
        c.func            = abc_pkg::FUNC_PROCESS;
        c.tx_ack_seq      = ack;
        c.handler_accepts = accepts;
        c.rx_payload_size = rx_size;
        return c;
    endfunction

    function automatic abc_pkg::cmd_t finish_cmd();
        abc_pkg::cmd_t c;
        c      = noise_cmd();
        c.func = abc_pkg::FUNC_FINISH;
        return c;
    endfunction

    // Mostly legal sizes, with zero, the limit, one past it and anything.
    function automatic logic [abc_pkg::SIZE_W-1:0] pick_post_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return ch_cfg.max_payload;
        if (r == 2)
            return ch_cfg.max_payload + abc_pkg::SIZE_W'(1);
        if (r == 3)
            return abc_pkg::SIZE_W'($urandom);
        return abc_pkg::SIZE_W'($urandom_range(1, ch_cfg.max_payload));
    endfunction

    // Mostly the next encoding in turn, so that frames get through; some
    // repeats and some junk.
    function automatic logic [abc_pkg::SEQ_W-1:0] pick_rx_seq();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return toggled_seq(ch_rx_seq);
        if (r == 7)
            return ch_rx_seq;
        return abc_pkg::SEQ_W'($urandom);
    endfunction

    function automatic logic [abc_pkg::SEQ_W-1:0] pick_ack();
        if ($urandom_range(0, 9) < 6)
            return ch_tx_seq;
        return abc_pkg::SEQ_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Driving.
    // ------------------------------------------------------------------------

    // Offers one event request, waits until the channel takes it, then
    // records the predicted result. Valid stays high into the next request
    // unless a burst ends; a gap always waits for a clock edge, so valid is
    // never lowered and raised in the same time step.
    task automatic send_item(input abc_pkg::cmd_t c);
        cmd_bus.valid           <= 1'b1;
        cmd_bus.func            <= c.func;
        cmd_bus.payload_size    <= c.payload_size;
        cmd_bus.rx_seq_in       <= c.rx_seq_in;
        cmd_bus.tx_ack_seq      <= c.tx_ack_seq;
        cmd_bus.handler_accepts <= c.handler_accepts;
        cmd_bus.rx_payload_size <= c.rx_payload_size;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        pending_results.push_back(predict_event(c));
        items_sent++;
        if (cmd_gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                cmd_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // Stops offering requests and waits until the channel has answered all
    // of them and has had time to settle.
    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [abc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [abc_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Loads all four registers while the channel is idle. The unused upper
    // byte of the sequence writes is random to show that it is dropped.
    task automatic program_regs(input abc_pkg::cfg_t c);
        wait_idle();
        write_reg(abc_pkg::REG_SEQ_FIRST,
                  {abc_pkg::SEQ_W'($urandom), c.seq_value_first});
        write_reg(abc_pkg::REG_SEQ_SECOND,
                  {abc_pkg::SEQ_W'($urandom), c.seq_value_second});
        write_reg(abc_pkg::REG_TIMEOUT,     c.timeout_limit);
        write_reg(abc_pkg::REG_MAX_PAYLOAD, c.max_payload);
        cfg_we <= 1'b0;
        @(posedge clk);
        ch_cfg = c;
    endtask

    // ------------------------------------------------------------------------
    // Receiver. Unless stalls are off, it stalls in segments of random kind
    // and length: always ready, every other cycle, coin flips, or rarely
    // ready. A hold-off request takes priority, counted down cycle by cycle.
    // ------------------------------------------------------------------------
    initial
    begin : rsp_receiver
        int hold_cnt;
        int seg_left;
        int seg_kind;
        bit phase_q;
        hold_cnt      = 0;
        seg_left      = 0;
        seg_kind      = 0;
        phase_q       = 1'b0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_len != 0)
            begin
                hold_cnt     = rsp_hold_len;
                rsp_hold_len = 0;
            end
            phase_q = !phase_q;
            if (hold_cnt != 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_cnt--;
            end
            else if (!rsp_stall_on)
                rsp_bus.ready <= 1'b1;
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(4, 40);
                    seg_kind = $urandom_range(0, 3);
                end
                seg_left--;
                case (seg_kind)
                    0:       rsp_bus.ready <= 1'b1;
                    1:       rsp_bus.ready <= phase_q;
                    2:       rsp_bus.ready <= 1'($urandom);
                    default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking. Every result request taken from the channel is held
    // against the oldest predicted result, one field at a time.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        fail_count++;
        // Past the first few dozen, errors are only counted.
        if (fail_count <= 50)
            $display("ERROR at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got_v,
                               input logic [15:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("result %0d field %s: got %0h, want %0h",
                                      rsp_count, name, got_v, want_v));
    endtask

    always @(posedge clk)
    begin : rsp_checker
        abc_pkg::rsp_t want;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          rsp_count));
            else
            begin
                want = pending_results.pop_front();
                check_field("post_status", 16'(rsp_bus.post_status),
                            16'(want.post_status));
                check_field("tx_seq_out", 16'(rsp_bus.tx_seq_out),
                            16'(want.tx_seq_out));
                check_field("deliver_valid", 16'(rsp_bus.deliver_valid),
                            16'(want.deliver_valid));
                check_field("deliver_size", rsp_bus.deliver_size,
                            want.deliver_size);
                check_field("rx_flag_write", 16'(rsp_bus.rx_flag_write),
                            16'(want.rx_flag_write));
                check_field("rx_flag_value", 16'(rsp_bus.rx_flag_value),
                            16'(want.rx_flag_value));
                check_field("process_ok", 16'(rsp_bus.process_ok),
                            16'(want.process_ok));
                check_field("tx_locked", 16'(rsp_bus.tx_locked),
                            16'(want.tx_locked));
                check_field("tx_acknowledged", 16'(rsp_bus.tx_acknowledged),
                            16'(want.tx_acknowledged));
                check_field("tx_timed_out", 16'(rsp_bus.tx_timed_out),
                            16'(want.tx_timed_out));
            end
            rsp_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Runs on the reset register values: size checks at both ends, the
    // busy refusal, ignored and repeated receive sequences, a delivered and
    // a refused frame, and finish with and without a pending frame.
    task automatic test_reset_behavior();
        send_item(post_cmd(16'd0));
        send_item(post_cmd(ch_cfg.max_payload + abc_pkg::SIZE_W'(1)));
        send_item(post_cmd(ch_cfg.max_payload));
        send_item(post_cmd(16'd1));                    // busy
        send_item(post_cmd(16'hFFFF));                 // too large, not busy
        send_item(frame_cmd(8'hFF));                   // neither encoding
        send_item(frame_cmd(ch_cfg.seq_value_second)); // new incoming frame
        send_item(frame_cmd(ch_cfg.seq_value_second)); // repeat, ignored
        send_item(process_cmd(~ch_tx_seq, 1'b1, 16'hFFFF));
        send_item(process_cmd(ch_tx_seq, 1'b1, 16'h0000));
        send_item(process_cmd(8'h00, 1'b0, 16'h1234));
        send_item(finish_cmd());                       // nothing pending
        // A refused frame must leave the transmit side locked even when the
        // acknowledge would match.
        send_item(post_cmd(16'd1));
        send_item(frame_cmd(ch_cfg.seq_value_first));
        send_item(process_cmd(ch_tx_seq, 1'b0, 16'h00FF));
        send_item(process_cmd(ch_tx_seq, 1'b1, 16'h0001));
        send_item(frame_cmd(ch_cfg.seq_value_second));
        send_item(finish_cmd());
    endtask

    // Timeout at a short limit, acknowledge winning over an expired timer,
    // and a limit of zero that expires without any tick.
    task automatic test_timeout();
        program_regs('{8'd1, 8'd2, 16'd3, 16'hFFFF});
        send_item(post_cmd(16'hFFFF));
        repeat (2)
            send_item(frame_cmd(8'h00));
        send_item(process_cmd(~ch_tx_seq, 1'b1, 16'd0));   // not yet expired
        send_item(frame_cmd(8'h00));
        send_item(process_cmd(ch_tx_seq, 1'b1, 16'd0));    // expired, ack wins
        send_item(post_cmd(16'd2));
        repeat (3)
            send_item(frame_cmd(8'h00));
        send_item(process_cmd(~ch_tx_seq, 1'b1, 16'd0));   // times out
        program_regs('{8'd1, 8'd2, 16'd0, 16'd256});
        send_item(post_cmd(16'd5));
        send_item(process_cmd(~ch_tx_seq, 1'b1, 16'd0));
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering back to back, so the channel fills and stops taking
    // requests. The sender then waits until every result is in.
    task automatic test_backpressure();
        cmd_gaps_on  = 1'b0;
        rsp_hold_len = 80;
        repeat (24)
            send_item(noise_cmd());
        wait_idle();
        cmd_gaps_on = 1'b1;
    endtask

    // One well-formed exchange: a post, some frames, one or two process
    // steps and sometimes a finish. For limits under 12 the frame count
    // straddles the limit, so that both timeouts and acknowledges happen.
    task automatic run_exchange();
        int n_frames;
        n_frames = $urandom_range(0, (ch_cfg.timeout_limit < 12) ?
                                     int'(ch_cfg.timeout_limit) + 2 : 12);
        send_item(post_cmd(pick_post_size()));
        repeat (n_frames)
            send_item(frame_cmd(pick_rx_seq()));
        repeat ($urandom_range(1, 2))
            send_item(process_cmd(pick_ack(), $urandom_range(0, 4) != 0,
                                  abc_pkg::SIZE_W'($urandom)));
        if ($urandom_range(0, 2) == 0)
            send_item(finish_cmd());
    endtask

    task automatic run_random_phase(input abc_pkg::cfg_t c, input int n_items);
        int stop_at;
        program_regs(c);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4))
                    send_item(noise_cmd());
            else
                run_exchange();
        end
    endtask

    // Random traffic under the reset values, both extreme settings, equal
    // encodings and two random settings.
    task automatic test_random_phases();
        abc_pkg::cfg_t c;
        run_random_phase('{8'd1, 8'd2, 16'd10, 16'd256}, 320);
        run_random_phase('{8'd0, 8'd255, 16'd1, 16'd1}, 320);
        run_random_phase('{8'd255, 8'd0, 16'hFFFF, 16'hFFFF}, 320);
        run_random_phase('{8'd7, 8'd7, 16'd5, 16'd100}, 320);
        repeat (2)
        begin
            c.seq_value_first  = abc_pkg::SEQ_W'($urandom);
            c.seq_value_second = abc_pkg::SEQ_W'($urandom);
            c.timeout_limit    = abc_pkg::LIMIT_W'($urandom_range(1, 20));
            c.max_payload      = abc_pkg::SIZE_W'($urandom_range(1, 16'hFFFF));
            run_random_phase(c, 320);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        cmd_bus.valid           = 1'b0;
        cmd_bus.func            = abc_pkg::FUNC_POST;
        cmd_bus.payload_size    = '0;
        cmd_bus.rx_seq_in       = '0;
        cmd_bus.tx_ack_seq      = '0;
        cmd_bus.handler_accepts = 1'b0;
        cmd_bus.rx_payload_size = '0;

        // The model starts from the reset state. The transmit sequence
        // starts at the reset value of the second encoding.
        ch_cfg        = '{abc_pkg::SEQ_FIRST_RST, abc_pkg::SEQ_SECOND_RST,
                          abc_pkg::TIMEOUT_RST, abc_pkg::MAX_PAYLOAD_RST};
        ch_tx_seq     = abc_pkg::SEQ_SECOND_RST;
        ch_rx_seq     = '0;
        ch_rx_pending = 1'b0;
        ch_tx_busy    = 1'b0;
        ch_timer_on   = 1'b0;
        ch_timer_cnt  = '0;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        test_reset_behavior();
        test_timeout();
        test_backpressure();
        test_random_phases();

        wait_idle();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("alternating_bit_channel: match");
        else
            $display("alternating_bit_channel: mismatch");
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial
    begin
        #4_000_000;
        $display("alternating_bit_channel: mismatch");
        $finish;
    end

endmodule
